// ===== rtl/core/usm_pkg.sv =====
// usm_pkg: constants, codes and types shared by the unsharp mask core.
// No dependencies; imported by usm_sharpen and unsharp_mask_3x3.
`default_nettype none

package usm_pkg;

   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;
   localparam int ADDR_W     = $clog2(MAX_WIDTH);
   localparam int SIZE_W     = 13;
   localparam int AMOUNT_W   = 10;
   localparam int THRESH_W   = 8;
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   localparam logic [SIZE_W-1:0]   SIZE_RESET   = SIZE_W'(256);
   localparam logic [AMOUNT_W-1:0] AMOUNT_RESET = AMOUNT_W'(128);
   localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(1);

   localparam logic CMD_DRAIN = 1'b1;

   typedef enum logic [1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_AMOUNT = 2'd2,
      CSR_THRESH = 2'd3
   } csr_index_type;

   typedef logic [31:0] pixel_type;

   // column_type[row], window_type[column]; column 0 oldest, row 0 top
   typedef pixel_type [2:0] column_type;
   typedef column_type [2:0] window_type;

   // nbhd_type[row][column], centre at [1][1]
   typedef pixel_type [2:0] nrow_type;
   typedef nrow_type [2:0] nbhd_type;

   typedef struct packed {
      logic frame_end;
   } tag_type;

   typedef struct packed {
      tag_type   tag;
      pixel_type pixel;
   } rsp_word_type;

   typedef struct packed {
      logic              live;
      logic              emit;
      logic              post;
      logic [1:0]        left_sel;
      logic [1:0]        ctr_sel;
      logic              top_rep;
      logic              bot_rep;
      logic              frame_end;
      logic              phantom;
      logic [ADDR_W-1:0] addr;
      pixel_type         px;
   } feed_type;

endpackage

`default_nettype wire

// ===== rtl/core/unsharp_mask_3x3.sv =====
// unsharp_mask_3x3: streaming 3x3 Gaussian unsharp mask, line stores, window, output queue.
// Depends on usm_pkg and usm_sharpen.
//
//   channel  direction  handshake             word
//   req      in         req_valid/req_ready   req_cmd, req_pixel_in
//   rsp      out        rsp_valid/rsp_ready   rsp_pixel_out, rsp_frame_end
//   csr      in         csr_wr_en             csr_index, csr_wr_data
//
// One word accepted per clock while req_ready is high; results leave via the output queue.
// Line stores are read at acceptance and written back in the cycle after; a
// back-to-back hit on the same column (one-pixel rows) is forwarded.
// The output queue holds 8 words; req_ready drops while 8 results are owed.
// Synchronous reset clears counters, window and queue; line stores are not cleared.
`default_nettype none

module unsharp_mask_3x3
   import usm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_cmd,
   input  pixel_type         req_pixel_in,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pixel_type         rsp_pixel_out,
   output logic              rsp_frame_end,
   input  logic              csr_wr_en,
   input  csr_index_type     csr_index,
   input  logic [SIZE_W-1:0] csr_wr_data
);

   logic [SIZE_W-1:0]   width_ff;
   logic [SIZE_W-1:0]   height_ff;
   logic [AMOUNT_W-1:0] amount_ff;
   logic [THRESH_W-1:0] thresh_ff;

   logic [SIZE_W-1:0]   w_eff;
   logic [SIZE_W-1:0]   h_eff;
   logic [SIZE_W-1:0]   h_p1;

   logic [SIZE_W-1:0]   col_ff, col_in;
   logic [SIZE_W-1:0]   row_ff, row_in;
   logic [SIZE_W-1:0]   col0, row0, col1, row1, col_nx;
   logic                col_wrap, restart, phantom, take, out_a, out_b, last;
   logic                accept;

   feed_type            feed_ff, feed_in;

   pixel_type           upper_mem  [MAX_WIDTH];
   pixel_type           middle_mem [MAX_WIDTH];
   pixel_type           upper_rd_ff, middle_rd_ff;
   logic [ADDR_W-1:0]   rd_addr;
   logic                fwd_hit_ff, fwd_hit_in;
   pixel_type           fwd_upper_ff, fwd_middle_ff;

   pixel_type           s1_top, s1_mid, s1_bot;
   logic                s1_wr;
   window_type          win_ff, win_in, shifted, base;
   nbhd_type            nb_ff, nb_in;
   logic [1:0]          src_row;
   logic                nb_valid_ff;
   tag_type             nb_tag_ff;

   logic                sh_valid;
   pixel_type           sh_pixel;
   tag_type             sh_tag;

   rsp_word_type        fifo_mem [FIFO_DEPTH];
   logic [FIFO_AW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_AW:0]    fifo_cnt_ff, fifo_cnt_in;
   logic [FIFO_AW:0]    occ_ff, occ_in;
   logic                pop;
   rsp_word_type        rsp_word;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SIZE_RESET;
         height_ff <= SIZE_RESET;
         amount_ff <= AMOUNT_RESET;
         thresh_ff <= THRESH_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_wr_data;
            CSR_HEIGHT: height_ff <= csr_wr_data;
            CSR_AMOUNT: amount_ff <= csr_wr_data[AMOUNT_W-1:0];
            CSR_THRESH: thresh_ff <= csr_wr_data[THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         w_eff = SIZE_W'(1);
      end else if (width_ff > SIZE_W'(MAX_WIDTH)) begin
         w_eff = SIZE_W'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff == '0) begin
         h_eff = SIZE_W'(1);
      end else if (height_ff > SIZE_W'(MAX_HEIGHT)) begin
         h_eff = SIZE_W'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
      h_p1 = h_eff + SIZE_W'(1);
   end

   // feed position, drain phase and output selection
   assign accept = req_valid && req_ready;

   always_comb begin
      col_wrap = col_ff >= w_eff;
      col0     = col_wrap ? '0 : col_ff;
      row0     = col_wrap ? row_ff + SIZE_W'(1) : row_ff;
      restart  = (row0 > h_p1) || ((row0 == h_p1) && (col0 != '0));
      col1     = restart ? '0 : col0;
      row1     = restart ? '0 : row0;
      phantom  = row1 >= h_eff;
      take     = accept && ((req_cmd == CMD_DRAIN) == phantom);
      out_a    = (col1 == '0) && (row1 >= SIZE_W'(2));
      out_b    = (col1 != '0) && (row1 >= SIZE_W'(1));
      last     = out_a && (row1 >= h_p1);
      col_nx   = col1 + SIZE_W'(1);
      rd_addr  = col1[ADDR_W-1:0];

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (!take) begin
            col_in = col1;
            row_in = row1;
         end else if (last) begin
            col_in = '0;
            row_in = '0;
         end else if (col_nx >= w_eff) begin
            col_in = '0;
            row_in = row1 + SIZE_W'(1);
         end else begin
            col_in = col_nx;
            row_in = row1;
         end
      end

      feed_in         = '0;
      feed_in.live    = take;
      feed_in.emit    = take && (out_a || out_b);
      feed_in.phantom = phantom;
      feed_in.addr    = rd_addr;
      feed_in.px      = req_pixel_in;
      if (out_a) begin
         // right edge of the row two back, taken before the shift
         feed_in.post      = 1'b0;
         feed_in.left_sel  = (w_eff == SIZE_W'(1)) ? 2'd2 : 2'd1;
         feed_in.ctr_sel   = 2'd2;
         feed_in.top_rep   = row1 == SIZE_W'(2);
         feed_in.bot_rep   = row1 >= h_p1;
         feed_in.frame_end = last;
      end else begin
         feed_in.post      = 1'b1;
         feed_in.left_sel  = (col1 == SIZE_W'(1)) ? 2'd1 : 2'd0;
         feed_in.ctr_sel   = 2'd1;
         feed_in.top_rep   = row1 == SIZE_W'(1);
         feed_in.bot_rep   = row1 >= h_eff;
         feed_in.frame_end = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         feed_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         feed_ff <= feed_in;
      end
   end

   // line stores: read at acceptance, written back in the cycle after
   always_ff @(posedge clock) begin
      if (s1_wr) begin
         upper_mem[feed_ff.addr]  <= s1_mid;
         middle_mem[feed_ff.addr] <= feed_ff.px;
      end
      upper_rd_ff  <= upper_mem[rd_addr];
      middle_rd_ff <= middle_mem[rd_addr];
   end

   assign fwd_hit_in = s1_wr && (feed_ff.addr == rd_addr);

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else begin
         fwd_hit_ff <= fwd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_upper_ff  <= s1_mid;
      fwd_middle_ff <= feed_ff.px;
   end

   // window shift and neighbourhood pick with edge replication
   always_comb begin
      s1_top  = fwd_hit_ff ? fwd_upper_ff : upper_rd_ff;
      s1_mid  = fwd_hit_ff ? fwd_middle_ff : middle_rd_ff;
      s1_bot  = feed_ff.phantom ? s1_mid : feed_ff.px;
      s1_wr   = feed_ff.live && !feed_ff.phantom;

      shifted[0] = win_ff[1];
      shifted[1] = win_ff[2];
      shifted[2] = {s1_bot, s1_mid, s1_top};
      win_in     = feed_ff.live ? shifted : win_ff;
      base       = feed_ff.post ? shifted : win_ff;

      for (int r = 0; r < 3; r++) begin
         src_row = 2'(r);
         if ((r == 0) && feed_ff.top_rep) begin
            src_row = 2'd1;
         end
         if ((r == 2) && feed_ff.bot_rep) begin
            src_row = 2'd1;
         end
         nb_in[r][0] = base[feed_ff.left_sel][src_row];
         nb_in[r][1] = base[feed_ff.ctr_sel][src_row];
         nb_in[r][2] = base[2][src_row];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff      <= '0;
         nb_valid_ff <= 1'b0;
      end else begin
         win_ff      <= win_in;
         nb_valid_ff <= feed_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      nb_ff               <= nb_in;
      nb_tag_ff.frame_end <= feed_ff.frame_end;
   end

   usm_sharpen u_sharpen (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (nb_valid_ff),
      .in_nbhd          (nb_ff),
      .in_tag           (nb_tag_ff),
      .amount_q8        (amount_ff),
      .detail_threshold (thresh_ff),
      .out_valid        (sh_valid),
      .out_pixel        (sh_pixel),
      .out_tag          (sh_tag)
   );

   // output queue; occupancy counts every result owed since acceptance
   assign pop = rsp_valid && rsp_ready;

   always_comb begin
      fifo_cnt_in = fifo_cnt_ff + (FIFO_AW+1)'(sh_valid) - (FIFO_AW+1)'(pop);
      occ_in      = occ_ff + (FIFO_AW+1)'(feed_in.emit) - (FIFO_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (sh_valid) begin
         fifo_mem[wr_ptr_ff] <= '{tag: sh_tag, pixel: sh_pixel};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
         occ_ff      <= '0;
      end else begin
         if (sh_valid) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_AW'(1);
         end
         fifo_cnt_ff <= fifo_cnt_in;
         occ_ff      <= occ_in;
      end
   end

   assign rsp_word      = fifo_mem[rd_ptr_ff];
   assign rsp_valid     = fifo_cnt_ff != '0;
   assign rsp_pixel_out = rsp_word.pixel;
   assign rsp_frame_end = rsp_word.tag.frame_end;
   assign req_ready     = occ_ff < (FIFO_AW+1)'(FIFO_DEPTH);

endmodule

`default_nettype wire

// ===== rtl/core/usm_sharpen.sv =====
// usm_sharpen: two-stage per-channel blur, threshold and gain on a 3x3 neighbourhood.
// Depends on usm_pkg.
`default_nettype none

module usm_sharpen
   import usm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  nbhd_type            in_nbhd,
   input  tag_type             in_tag,
   input  logic [AMOUNT_W-1:0] amount_q8,
   input  logic [THRESH_W-1:0] detail_threshold,
   output logic                out_valid,
   output pixel_type           out_pixel,
   output tag_type             out_tag
);

   logic [11:0]        sum_w  [3];
   logic signed [8:0]  diff_w [3];
   logic [8:0]         mag_w  [3];

   logic               a_valid_ff;
   logic [7:0]         a_alpha_ff;
   logic [7:0]         a_src_ff  [3];
   logic signed [8:0]  a_diff_ff [3];
   tag_type            a_tag_ff;

   logic signed [19:0] prod_w [3];
   logic signed [20:0] t_w    [3];
   pixel_type          pixel_in;

   logic               out_valid_ff;
   pixel_type          out_pixel_ff;
   tag_type            out_tag_ff;

   // 1-2-1 x 1-2-1 sum, difference from centre, small details cored out
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         sum_w[ch] = 12'(in_nbhd[0][0][ch*8 +: 8])
                   + 12'({in_nbhd[0][1][ch*8 +: 8], 1'b0})
                   + 12'(in_nbhd[0][2][ch*8 +: 8])
                   + 12'({in_nbhd[1][0][ch*8 +: 8], 1'b0})
                   + 12'({in_nbhd[1][1][ch*8 +: 8], 2'b00})
                   + 12'({in_nbhd[1][2][ch*8 +: 8], 1'b0})
                   + 12'(in_nbhd[2][0][ch*8 +: 8])
                   + 12'({in_nbhd[2][1][ch*8 +: 8], 1'b0})
                   + 12'(in_nbhd[2][2][ch*8 +: 8]);
         diff_w[ch] = $signed({1'b0, in_nbhd[1][1][ch*8 +: 8]})
                    - $signed({1'b0, sum_w[ch][11:4]});
         mag_w[ch]  = diff_w[ch][8] ? 9'(-diff_w[ch]) : 9'(diff_w[ch]);
         if (mag_w[ch] < {1'b0, detail_threshold}) begin
            diff_w[ch] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      a_alpha_ff <= in_nbhd[1][1][31:24];
      a_tag_ff   <= in_tag;
      for (int ch = 0; ch < 3; ch++) begin
         a_src_ff[ch]  <= in_nbhd[1][1][ch*8 +: 8];
         a_diff_ff[ch] <= diff_w[ch];
      end
   end

   // src*256 + gain*diff, negative clips to zero, above 255 saturates
   always_comb begin
      pixel_in = {a_alpha_ff, 24'h0};
      for (int ch = 0; ch < 3; ch++) begin
         prod_w[ch] = $signed({1'b0, amount_q8}) * a_diff_ff[ch];
         t_w[ch]    = 21'(prod_w[ch]) + $signed({5'b0, a_src_ff[ch], 8'h00});
         if (t_w[ch][20]) begin
            pixel_in[ch*8 +: 8] = 8'h00;
         end else if (t_w[ch][19:16] != 4'h0) begin
            pixel_in[ch*8 +: 8] = 8'hFF;
         end else begin
            pixel_in[ch*8 +: 8] = t_w[ch][15:8];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      out_pixel_ff <= pixel_in;
      out_tag_ff   <= a_tag_ff;
   end

   assign out_valid = out_valid_ff;
   assign out_pixel = out_pixel_ff;
   assign out_tag   = out_tag_ff;

endmodule

`default_nettype wire
